FILE: hdl/shelf_packing_placer_macros.svh
`ifndef SHELF_PACKING_PLACER_MACROS_SVH
`define SHELF_PACKING_PLACER_MACROS_SVH

// Checks sampled on clk, off while rst_n is low.
`define SPP_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define SPP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/spp_pkg.sv
`default_nettype none

package spp_pkg;

    localparam int PIECE_W     = 12;
    localparam int OUT_COORD_W = 16;
    localparam int CFG_DATA_W  = 16;
    localparam int CFG_IDX_W   = 2;
    localparam int LEN_W       = 16;
    localparam int SPACE_W     = 8;

    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    localparam cfg_idx_t CFG_STRIP_LENGTH = 2'd0;
    localparam cfg_idx_t CFG_EDGE_MARGIN  = 2'd1;
    localparam cfg_idx_t CFG_CUT_GAP      = 2'd2;

    localparam logic [LEN_W-1:0]   STRIP_LENGTH_RST = 16'd1000;
    localparam logic [SPACE_W-1:0] EDGE_MARGIN_RST  = 8'd6;
    localparam logic [SPACE_W-1:0] CUT_GAP_RST      = 8'd3;

endpackage

`default_nettype wire

FILE: hdl/shelf_packing_placer.sv
// Shelf packing placer: next-fit level strip packing, one rectangle per item.
// Input channel in_valid/in_ready carries piece_width, piece_height, rotated
// and last_piece. Output channel out_valid/out_ready carries the position,
// placed and opened_shelf flags, the running layout height, the overflow flag
// and last_result. One result item per input item, in order.
// Path: an accepted item waits in the input register, then moves to the result
// register once the output is free. Throughput: one item per cycle unless the
// receiver stalls; the shelf state (cursor, base, tallest reach) is updated in
// the same cycle the result register is loaded, so the next item sees it at once.
// A stalled receiver holds the result register; one more item is taken into
// the input register, after which in_ready drops until the output drains.
// Configuration: cfg_write with cfg_index/cfg_data, only while idle. Any write
// to a known register restarts the layout from the edge margin.
// Reset: strip length 1000, edge margin 6, cut gap 3, layout state at the
// edge margin, both channel registers empty.
`default_nettype none

module shelf_packing_placer #(
    parameter int DIM_BITS   = 12,
    parameter int COORD_BITS = 16
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_write,
    input  wire spp_pkg::cfg_idx_t                 cfg_index,
    input  wire logic [spp_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic [spp_pkg::PIECE_W-1:0]       piece_width,
    input  wire logic [spp_pkg::PIECE_W-1:0]       piece_height,
    input  wire logic                              rotated,
    input  wire logic                              last_piece,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic [spp_pkg::OUT_COORD_W-1:0]        pos_along,
    output logic [spp_pkg::OUT_COORD_W-1:0]        pos_across,
    output logic                                   placed,
    output logic                                   opened_shelf,
    output logic [spp_pkg::OUT_COORD_W-1:0]        layout_height,
    output logic                                   height_overflow,
    output logic                                   last_result
);
    import spp_pkg::*;

    `include "shelf_packing_placer_macros.svh"

    localparam int DW = (DIM_BITS < PIECE_W) ? DIM_BITS : PIECE_W;
    localparam int AW = ((COORD_BITS > LEN_W) ? COORD_BITS : LEN_W) + 2;
    localparam logic [COORD_BITS-1:0] COORD_MAX = '1;

    typedef logic [COORD_BITS-1:0] coord_t;
    typedef logic [AW-1:0] wide_t;

    function automatic coord_t sat_coord(input wide_t v);
        coord_t r;
        r = (v > AW'(COORD_MAX)) ? COORD_MAX : v[COORD_BITS-1:0];
        return r;
    endfunction

    logic [LEN_W-1:0]   strip_length_reg;
    logic [SPACE_W-1:0] edge_margin_reg;
    logic [SPACE_W-1:0] cut_gap_reg;

    coord_t shelf_cursor_reg, shelf_cursor_next;
    coord_t shelf_base_reg, shelf_base_next;
    coord_t tallest_reach_reg, tallest_reach_next;

    logic          s1_valid_reg;
    logic [DW-1:0] s1_width_reg;
    logic [DW-1:0] s1_height_reg;
    logic          s1_rotated_reg;
    logic          s1_last_reg;

    logic   out_valid_reg;
    coord_t pos_along_reg, pos_along_next;
    coord_t pos_across_reg, pos_across_next;
    logic   placed_reg, placed_next;
    logic   opened_reg, opened_next;
    coord_t height_reg;
    logic   overflow_reg, overflow_next;
    logic   last_reg;

    logic          load;
    logic          cfg_hit;
    logic [SPACE_W-1:0] margin_new;
    logic [DW-1:0] along;
    logic [DW-1:0] across;
    wide_t         strip_eff;
    coord_t        margin_c;
    logic          fits_empty;
    logic          fits_cursor;
    logic          open_shelf;
    coord_t        cursor_eff;
    coord_t        base_eff;
    coord_t        top;

    assign load     = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || load;
    assign cfg_hit  = cfg_write && (cfg_index == CFG_STRIP_LENGTH ||
                      cfg_index == CFG_EDGE_MARGIN || cfg_index == CFG_CUT_GAP);
    assign margin_new = (cfg_index == CFG_EDGE_MARGIN) ? cfg_data[SPACE_W-1:0]
                                                       : edge_margin_reg;

    always_comb
    begin
        along      = s1_rotated_reg ? s1_width_reg : s1_height_reg;
        across     = s1_rotated_reg ? s1_height_reg : s1_width_reg;
        strip_eff  = (AW'(strip_length_reg) < AW'(COORD_MAX)) ? AW'(strip_length_reg)
                                                              : AW'(COORD_MAX);
        margin_c   = COORD_BITS'(edge_margin_reg);
        fits_empty = (AW'(margin_c) + AW'(along) + AW'(edge_margin_reg)) <= strip_eff;
        fits_cursor = (AW'(shelf_cursor_reg) + AW'(along) + AW'(edge_margin_reg))
                      <= strip_eff;
        open_shelf = fits_empty && !fits_cursor;
        cursor_eff = open_shelf ? margin_c : shelf_cursor_reg;
        base_eff   = open_shelf ? sat_coord(AW'(tallest_reach_reg) + AW'(cut_gap_reg))
                                : shelf_base_reg;
        top        = sat_coord(AW'(base_eff) + AW'(across));

        shelf_cursor_next  = shelf_cursor_reg;
        shelf_base_next    = shelf_base_reg;
        tallest_reach_next = tallest_reach_reg;
        pos_along_next     = '0;
        pos_across_next    = '0;
        placed_next        = 1'b0;
        opened_next        = 1'b0;
        if (fits_empty)
        begin
            shelf_cursor_next  = sat_coord(AW'(cursor_eff) + AW'(along) + AW'(cut_gap_reg));
            shelf_base_next    = base_eff;
            tallest_reach_next = (top > tallest_reach_reg) ? top : tallest_reach_reg;
            pos_along_next     = cursor_eff;
            pos_across_next    = base_eff;
            placed_next        = 1'b1;
            opened_next        = open_shelf;
        end
        overflow_next = (tallest_reach_next == COORD_MAX) || (shelf_base_next == COORD_MAX);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strip_length_reg  <= STRIP_LENGTH_RST;
            edge_margin_reg   <= EDGE_MARGIN_RST;
            cut_gap_reg       <= CUT_GAP_RST;
            shelf_cursor_reg  <= COORD_BITS'(EDGE_MARGIN_RST);
            shelf_base_reg    <= COORD_BITS'(EDGE_MARGIN_RST);
            tallest_reach_reg <= COORD_BITS'(EDGE_MARGIN_RST);
            s1_valid_reg      <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_hit)
            begin
                case (cfg_index)
                    CFG_STRIP_LENGTH: strip_length_reg <= cfg_data[LEN_W-1:0];
                    CFG_EDGE_MARGIN:  edge_margin_reg  <= cfg_data[SPACE_W-1:0];
                    CFG_CUT_GAP:      cut_gap_reg      <= cfg_data[SPACE_W-1:0];
                    default:          strip_length_reg <= strip_length_reg;
                endcase
                shelf_cursor_reg  <= COORD_BITS'(margin_new);
                shelf_base_reg    <= COORD_BITS'(margin_new);
                tallest_reach_reg <= COORD_BITS'(margin_new);
            end
            else if (load)
            begin
                if (s1_last_reg)
                begin
                    shelf_cursor_reg  <= margin_c;
                    shelf_base_reg    <= margin_c;
                    tallest_reach_reg <= margin_c;
                end
                else
                begin
                    shelf_cursor_reg  <= shelf_cursor_next;
                    shelf_base_reg    <= shelf_base_next;
                    tallest_reach_reg <= tallest_reach_next;
                end
            end

            if (in_ready)
                s1_valid_reg <= in_valid;
            if (load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_width_reg   <= piece_width[DW-1:0];
            s1_height_reg  <= piece_height[DW-1:0];
            s1_rotated_reg <= rotated;
            s1_last_reg    <= last_piece;
        end
        if (load)
        begin
            pos_along_reg  <= pos_along_next;
            pos_across_reg <= pos_across_next;
            placed_reg     <= placed_next;
            opened_reg     <= opened_next;
            height_reg     <= tallest_reach_next;
            overflow_reg   <= overflow_next;
            last_reg       <= s1_last_reg;
        end
    end

    assign out_valid       = out_valid_reg;
    assign pos_along       = OUT_COORD_W'(pos_along_reg);
    assign pos_across      = OUT_COORD_W'(pos_across_reg);
    assign placed          = placed_reg;
    assign opened_shelf    = opened_reg;
    assign layout_height   = OUT_COORD_W'(height_reg);
    assign height_overflow = overflow_reg;
    assign last_result     = last_reg;

    `SPP_ASSERT_IMP(a_reach_above_base, 1'b1, tallest_reach_reg >= shelf_base_reg, "tallest reach below shelf base")
    `SPP_ASSERT_NEXT(a_last_restarts, load && s1_last_reg && !cfg_hit, shelf_cursor_reg == shelf_base_reg && shelf_base_reg == tallest_reach_reg, "layout not restarted after last item")
    `SPP_ASSERT_IMP(a_stall_blocks_input, out_valid_reg && !out_ready && s1_valid_reg, !in_ready, "input taken while both stages are full")
    `SPP_ASSERT_NEXT(a_load_shows_output, load, out_valid_reg, "loaded result not presented")

endmodule

`default_nettype wire

FILE: bench/tb_shelf_packing_placer.sv
`timescale 1ns / 1ps

module tb_shelf_packing_placer;
    import spp_pkg::*;

    localparam int COORD_MAX   = (1 << OUT_COORD_W) - 1;
    localparam int CYCLE_LIMIT = 500000;
    localparam cfg_idx_t CFG_UNUSED = 2'd3;

    typedef struct packed {
        logic [OUT_COORD_W-1:0] along_at;
        logic [OUT_COORD_W-1:0] base_at;
        logic                   placed;
        logic                   opened;
        logic [OUT_COORD_W-1:0] height;
        logic                   overflow;
        logic                   last;
    } placement_t;

    logic                    clk;
    logic                    rst_n        = 1'b0;
    logic                    cfg_write    = 1'b0;
    cfg_idx_t                cfg_index    = CFG_STRIP_LENGTH;
    logic [CFG_DATA_W-1:0]   cfg_data     = '0;
    logic                    in_valid     = 1'b0;
    logic                    in_ready;
    logic [PIECE_W-1:0]      piece_width  = '0;
    logic [PIECE_W-1:0]      piece_height = '0;
    logic                    rotated      = 1'b0;
    logic                    last_piece   = 1'b0;
    logic                    out_valid;
    logic                    out_ready    = 1'b0;
    logic [OUT_COORD_W-1:0]  pos_along;
    logic [OUT_COORD_W-1:0]  pos_across;
    logic                    placed;
    logic                    opened_shelf;
    logic [OUT_COORD_W-1:0]  layout_height;
    logic                    height_overflow;
    logic                    last_result;

    // predictor copy of the registers and the layout state
    logic [LEN_W-1:0]        strip_len = STRIP_LENGTH_RST;
    logic [SPACE_W-1:0]      margin_v  = EDGE_MARGIN_RST;
    logic [SPACE_W-1:0]      gap_v     = CUT_GAP_RST;
    int                      shelf_pos;
    int                      shelf_floor;
    int                      top_reach;

    placement_t              pending_places[$];
    int                      mismatches  = 0;
    int                      cycle_count = 0;
    int                      n_items     = 0;
    int                      n_placed    = 0;
    int                      n_shelves   = 0;
    int                      n_saturated = 0;
    int                      reg_writes  = 0;
    int                      tx_calm     = 0;
    logic                    quiet       = 1'b0;

    shelf_packing_placer dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_write       (cfg_write),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .piece_width     (piece_width),
        .piece_height    (piece_height),
        .rotated         (rotated),
        .last_piece      (last_piece),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .pos_along       (pos_along),
        .pos_across      (pos_across),
        .placed          (placed),
        .opened_shelf    (opened_shelf),
        .layout_height   (layout_height),
        .height_overflow (height_overflow),
        .last_result     (last_result)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic int sat_coord(input int v);
        return (v > COORD_MAX) ? COORD_MAX : v;
    endfunction

    function automatic void restart_layout();
        shelf_pos   = sat_coord(int'(margin_v));
        shelf_floor = shelf_pos;
        top_reach   = shelf_pos;
    endfunction

    function automatic void apply_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
        case (idx)
            CFG_STRIP_LENGTH: strip_len = value[LEN_W-1:0];
            CFG_EDGE_MARGIN:  margin_v  = value[SPACE_W-1:0];
            CFG_CUT_GAP:      gap_v     = value[SPACE_W-1:0];
            default:          return;
        endcase
        restart_layout();
    endfunction

    function automatic placement_t place_piece(input logic [PIECE_W-1:0] w, h,
                                               input logic rot, lst);
        placement_t r;
        int along;
        int across;
        int limit;
        int margin;
        int top;
        r      = '0;
        along  = rot ? int'(w) : int'(h);
        across = rot ? int'(h) : int'(w);
        margin = sat_coord(int'(margin_v));
        limit  = int'(strip_len) - int'(margin_v);
        if (margin + along <= limit)
        begin
            if (shelf_pos + along > limit)
            begin
                shelf_pos   = margin;
                shelf_floor = sat_coord(top_reach + int'(gap_v));
                r.opened    = 1'b1;
            end
            r.along_at = OUT_COORD_W'(shelf_pos);
            r.base_at  = OUT_COORD_W'(shelf_floor);
            r.placed   = 1'b1;
            shelf_pos  = sat_coord(shelf_pos + along + int'(gap_v));
            top        = sat_coord(shelf_floor + across);
            if (top > top_reach)
                top_reach = top;
        end
        r.height   = OUT_COORD_W'(top_reach);
        r.overflow = (top_reach == COORD_MAX) || (shelf_floor == COORD_MAX);
        r.last     = lst;
        if (lst)
            restart_layout();
        return r;
    endfunction

    task automatic report_mismatch(input string field, input int got, input int want_v);
        $display("%0t: %s mismatch, got %0d expected %0d", $time, field, got, want_v);
        mismatches++;
    endtask

    task automatic send_piece(input logic [PIECE_W-1:0] w, h, input logic rot, lst);
        placement_t want;
        int gap_len;
        gap_len = 0;
        if (!quiet)
        begin
            if (tx_calm > 0)
                tx_calm--;
            else if ($urandom_range(0, 99) < 3)
                tx_calm = $urandom_range(20, 150);
            else if ($urandom_range(0, 3) == 0)
                gap_len = $urandom_range(1, 14);
        end
        if (gap_len > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap_len) @(posedge clk);
        end
        in_valid     <= 1'b1;
        piece_width  <= w;
        piece_height <= h;
        rotated      <= rot;
        last_piece   <= lst;
        do
            @(posedge clk);
        while (!in_ready);
        want = place_piece(w, h, rot, lst);
        pending_places.push_back(want);
        n_items++;
        n_placed    += int'(want.placed);
        n_shelves   += int'(want.opened);
        n_saturated += int'(want.overflow);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (pending_places.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        apply_reg(idx, value);
        cfg_write <= 1'b0;
        @(posedge clk);
        reg_writes++;
    endtask

    function automatic int pick_len(input int cap);
        int c;
        c = (cap > 4095) ? 4095 : cap;
        case ($urandom_range(0, 7))
            0:       return 0;
            1:       return c;
            2, 3:    return $urandom_range(0, (c > 63) ? 63 : c);
            default: return $urandom_range(0, c);
        endcase
    endfunction

    task automatic shuffle_registers();
        logic [SPACE_W-1:0] v;
        if ($urandom_range(0, 1))
        begin
            case ($urandom_range(0, 7))
                0:       write_reg(CFG_STRIP_LENGTH, 16'h0000);
                1:       write_reg(CFG_STRIP_LENGTH, 16'hFFFF);
                2:       write_reg(CFG_STRIP_LENGTH, 16'($urandom_range(1, 600)));
                3:       write_reg(CFG_STRIP_LENGTH, 16'($urandom_range(4000, 9000)));
                default: write_reg(CFG_STRIP_LENGTH, 16'($urandom_range(600, 20000)));
            endcase
        end
        if ($urandom_range(0, 1))
        begin
            case ($urandom_range(0, 3))
                0:       v = '0;
                1:       v = '1;
                default: v = SPACE_W'($urandom);
            endcase
            write_reg(CFG_EDGE_MARGIN, {8'($urandom), v});
        end
        if ($urandom_range(0, 1))
        begin
            case ($urandom_range(0, 3))
                0:       v = '0;
                1:       v = '1;
                default: v = SPACE_W'($urandom);
            endcase
            write_reg(CFG_CUT_GAP, {8'($urandom), v});
        end
        if ($urandom_range(0, 7) == 0)
            write_reg(CFG_UNUSED, 16'($urandom));
    endtask

    task automatic test_reset_values();
        send_piece(12'd0, 12'd0, 1'b0, 1'b0);
        send_piece(12'hFFF, 12'hFFF, 1'b0, 1'b0);
        send_piece(12'd988, 12'd10, 1'b1, 1'b0);
        send_piece(12'd10, 12'd989, 1'b0, 1'b0);
        send_piece(12'hFFF, 12'd0, 1'b0, 1'b0);
        send_piece(12'd5, 12'd7, 1'b1, 1'b1);
        send_piece(12'd0, 12'd0, 1'b1, 1'b0);
    endtask

    task automatic test_register_edges();
        drain_results();
        write_reg(CFG_STRIP_LENGTH, 16'h0000);
        send_piece(12'd0, 12'd0, 1'b0, 1'b0);
        drain_results();
        write_reg(CFG_EDGE_MARGIN, 16'hFFFF);
        write_reg(CFG_STRIP_LENGTH, 16'd510);
        send_piece(12'd0, 12'hFFF, 1'b1, 1'b0);
        drain_results();
        write_reg(CFG_UNUSED, 16'hFFFF);
        send_piece(12'd0, 12'd0, 1'b1, 1'b0);
        drain_results();
        write_reg(CFG_CUT_GAP, 16'h5AFF);
        send_piece(12'd0, 12'd0, 1'b0, 1'b1);
    endtask

    task automatic test_height_saturation();
        int k;
        drain_results();
        write_reg(CFG_EDGE_MARGIN, 16'hA500);
        write_reg(CFG_CUT_GAP, 16'h00FF);
        write_reg(CFG_STRIP_LENGTH, 16'd4095);
        for (k = 0; k < 18; k++)
            send_piece(12'hFFF, 12'hFFF, 1'b1, k == 17);
    endtask

    task automatic test_random_layouts(input int item_goal);
        int sent;
        int n;
        int k;
        int usable;
        int along;
        int across;
        logic rot;
        logic lst;
        logic [PIECE_W-1:0] w;
        logic [PIECE_W-1:0] h;
        sent = 0;
        while (sent < item_goal)
        begin
            drain_results();
            shuffle_registers();
            repeat ($urandom_range(1, 4))
            begin
                if ($urandom_range(0, 9) == 0)
                    drain_results();
                n = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 30);
                for (k = 0; k < n; k++)
                begin
                    usable = int'(strip_len) - 2 * int'(margin_v);
                    rot    = 1'($urandom_range(0, 1));
                    lst    = (k == n - 1);
                    if ($urandom_range(0, 9) < 8 && usable >= 0)
                    begin
                        along  = pick_len(usable);
                        across = pick_len(4095);
                        w = PIECE_W'(rot ? along : across);
                        h = PIECE_W'(rot ? across : along);
                    end
                    else
                    begin
                        w = PIECE_W'($urandom);
                        h = PIECE_W'($urandom);
                        if ($urandom_range(0, 19) == 0)
                            lst = ~lst;
                    end
                    send_piece(w, h, rot, lst);
                    sent++;
                end
            end
        end
    endtask

    task automatic test_back_to_back();
        drain_results();
        quiet = 1'b1;
        test_random_layouts(150);
    endtask

    initial
    begin : receiver
        int stall;
        int calm;
        stall = 0;
        calm  = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (quiet || calm > 0)
            begin
                out_ready <= 1'b1;
                if (calm > 0)
                    calm--;
            end
            else if (stall > 0)
            begin
                out_ready <= 1'b0;
                stall--;
            end
            else if ($urandom_range(0, 199) == 0)
            begin
                out_ready <= 1'b1;
                calm = $urandom_range(30, 200);
            end
            else if ($urandom_range(0, 7) == 0)
            begin
                out_ready <= 1'b0;
                stall = $urandom_range(0, 13);
            end
            else
                out_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin : check_results
        placement_t want;
        if (rst_n && out_valid === 1'b1 && out_ready)
        begin
            if (pending_places.size() == 0)
                report_mismatch("unexpected result item", 1, 0);
            else
            begin
                want = pending_places.pop_front();
                if (pos_along !== want.along_at)
                    report_mismatch("pos_along", int'(pos_along), int'(want.along_at));
                if (pos_across !== want.base_at)
                    report_mismatch("pos_across", int'(pos_across), int'(want.base_at));
                if (placed !== want.placed)
                    report_mismatch("placed", int'(placed), int'(want.placed));
                if (opened_shelf !== want.opened)
                    report_mismatch("opened_shelf", int'(opened_shelf), int'(want.opened));
                if (layout_height !== want.height)
                    report_mismatch("layout_height", int'(layout_height), int'(want.height));
                if (height_overflow !== want.overflow)
                    report_mismatch("height_overflow", int'(height_overflow),
                                    int'(want.overflow));
                if (last_result !== want.last)
                    report_mismatch("last_result", int'(last_result), int'(want.last));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d items pending",
                     cycle_count, pending_places.size());
            $display("tb_shelf_packing_placer NOT OK");
            $finish;
        end
    end

    initial
    begin
        restart_layout();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_values();
        test_register_edges();
        test_height_saturation();
        test_random_layouts(1500);
        test_back_to_back();
        drain_results();
        repeat (10) @(posedge clk);
        $display("%0d pieces: %0d placed, %0d rejected, %0d new shelves, %0d saturated",
                 n_items, n_placed, n_items - n_placed, n_shelves, n_saturated);
        $display("%0d register writes, %0d mismatches", reg_writes, mismatches);
        if (mismatches == 0)
            $display("tb_shelf_packing_placer OK");
        else
            $display("tb_shelf_packing_placer NOT OK");
        $finish;
    end

endmodule

FILE: shelf_packing_placer.f
+incdir+hdl
hdl/spp_pkg.sv
hdl/shelf_packing_placer.sv
bench/tb_shelf_packing_placer.sv
